@@ rtl/uers_pkg.sv @@
// Shared types and constants for the ultrasonic echo ranging sequencer.
// Depends on nothing; every other file of the block uses it by scoped names.
package uers_pkg;

	// Timer width; the stamp field carries up to 16 bits of it
	localparam int unsigned STAMP_BITS   = 16;
	localparam int unsigned SENSOR_COUNT = 4;
	localparam int unsigned STAMP_W      = 16;
	localparam int unsigned USED_BITS    = (STAMP_BITS < STAMP_W) ? STAMP_BITS : STAMP_W;
	localparam int unsigned SENSOR_W     = $clog2(SENSOR_COUNT);

	// Speed of sound scaling: travel time * 343 / 2 gives micrometres
	localparam int unsigned SOUND_NUM = 343;
	localparam int unsigned SOUND_DEN = 2;
	localparam int unsigned NUM_W     = $clog2(SOUND_NUM + 1);
	localparam int unsigned DIST_W    = 24;
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	typedef enum logic [1:0] {
		FUNC_START = 2'd0,
		FUNC_EDGE  = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [SENSOR_W-1:0] {
		POS_FRONT = 2'd0,
		POS_BACK  = 2'd1,
		POS_LEFT  = 2'd2,
		POS_RIGHT = 2'd3
	} sensor_t;

	// One command held in the input register
	typedef struct packed {
		func_t               func;
		sensor_t             sensor;
		logic [STAMP_W-1:0]  stamp;
	} cmd_t;

	// One result as computed and held in the output register
	typedef struct packed {
		logic                trig_fire;
		logic [SENSOR_W-1:0] trig_sensor;
		logic                done_res;
		logic [SENSOR_W-1:0] done_sensor;
		logic                sample_kept;
		logic                read_valid;
		logic [DIST_W-1:0]   distance_um;
	} res_t;

endpackage

@@ rtl/uers_cmd_if.sv @@
// Valid/ready channel interfaces for commands and results.
// Depends on uers_pkg for field widths.
interface uers_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    func;
	logic [uers_pkg::SENSOR_W-1:0] sensor;
	logic [uers_pkg::STAMP_W-1:0]  stamp;

	modport source (output valid, output func, output sensor, output stamp, input ready);
	modport sink   (input valid, input func, input sensor, input stamp, output ready);
endinterface

interface uers_res_if;
	logic                          valid;
	logic                          ready;
	logic                          trig_fire;
	logic [uers_pkg::SENSOR_W-1:0] trig_sensor;
	logic                          done_res;
	logic [uers_pkg::SENSOR_W-1:0] done_sensor;
	logic                          sample_kept;
	logic                          read_valid;
	logic [uers_pkg::DIST_W-1:0]   distance_um;

	modport source (output valid, output trig_fire, output trig_sensor, output done_res,
		output done_sensor, output sample_kept, output read_valid, output distance_um,
		input ready);
	modport sink (input valid, input trig_fire, input trig_sensor, input done_res,
		input done_sensor, input sample_kept, input read_valid, input distance_um,
		output ready);
endinterface

@@ rtl/ultrasonic_echo_ranging_sequencer.sv @@
// Top level of the ultrasonic echo ranging sequencer: input and result registers
// around the control logic. Depends on uers_pkg, uers_cmd_if/uers_res_if, uers_ctrl.
//
// Usage:
//   cmd (sink) takes one command per transfer: func start / edge / read, the
//   sensor index and the timer stamp of an echo edge. res (source) returns
//   exactly one result per command, in order.
//   A command passes through the input register and then the result register
//   before its result shows on res.
//   Throughput: one command per cycle while res takes results; the state
//   update and the constant multiply for a read both fit between the input and result registers.
//   A command that follows a write of its sensor sees the new value.
//   Stall: when res.ready is low the result holds, the input register still
//   takes one more command, and cmd.ready then drops until res moves again.
//   Reset (arst_n low): both registers empty, nothing armed, all stored travel
//   times zero; no result is pending.
//   The back sensor has no trigger line: starting it arms it without a pulse.
module ultrasonic_echo_ranging_sequencer (
	input logic       clk,
	input logic       arst_n,
	uers_cmd_if.sink  cmd,
	uers_res_if.source res
);
	logic             cmd_valid_s1;
	uers_pkg::cmd_t   cmd_s1;
	logic             res_valid_s2;
	uers_pkg::res_t   res_s2;
	uers_pkg::res_t   res_next;
	logic             load_s2;
	logic             adv;

	// Result register loads when empty or being drained
	assign load_s2   = !res_valid_s2 || res.ready;
	assign adv       = cmd_valid_s1 && load_s2;
	assign cmd.ready = !cmd_valid_s1 || load_s2;

	// Hold the accepted command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			cmd_valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1.func   <= uers_pkg::func_t'(cmd.func);
			cmd_s1.sensor <= uers_pkg::sensor_t'(cmd.sensor);
			cmd_s1.stamp  <= cmd.stamp;
		end
	end

	uers_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cmd    (cmd_s1),
		.res    (res_next)
	);

	// Hold the result until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (load_s2) begin
			res_valid_s2 <= cmd_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_next;
		end
	end

	assign res.valid       = res_valid_s2;
	assign res.trig_fire   = res_s2.trig_fire;
	assign res.trig_sensor = res_s2.trig_sensor;
	assign res.done_res    = res_s2.done_res;
	assign res.done_sensor = res_s2.done_sensor;
	assign res.sample_kept = res_s2.sample_kept;
	assign res.read_valid  = res_s2.read_valid;
	assign res.distance_um = res_s2.distance_um;

	// A read result never carries trigger or completion flags
	a_read_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_s2 && res_s2.read_valid) |-> (!res_s2.trig_fire && !res_s2.done_res))
		else $error("read result mixed with event flags");

	// The back sensor is never triggered
	a_no_back_trig: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_s2 && res_s2.trig_fire) |->
		(res_s2.trig_sensor != uers_pkg::POS_BACK))
		else $error("trigger fired on back sensor");

	// A kept sample only comes with a completion
	a_kept_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_s2 && res_s2.sample_kept) |-> res_s2.done_res)
		else $error("sample kept without completion");

	// A stalled result stays pending and the input register does not advance
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_s2 && !res.ready && cmd_valid_s1) |=> (res_valid_s2 && cmd_valid_s1))
		else $error("pipeline lost an item during stall");
endmodule

@@ rtl/uers_range_calc.sv @@
// Converts a stored travel time into micrometres (time * 343 / 2, saturated).
// Depends on uers_pkg.
module uers_range_calc (
	input  logic [uers_pkg::USED_BITS-1:0] travel,
	output logic [uers_pkg::DIST_W-1:0]    distance_um
);
	localparam int unsigned PROD_W = uers_pkg::USED_BITS + uers_pkg::NUM_W;
	localparam int unsigned HALF_W = PROD_W - 1;
	localparam int unsigned WIDE_W = (HALF_W > uers_pkg::DIST_W) ? HALF_W : uers_pkg::DIST_W;

	logic [PROD_W-1:0] prod;
	logic [WIDE_W-1:0] wide;

	// Multiply by the constant, halve, clamp to the field
	always_comb begin
		prod = PROD_W'(travel) * PROD_W'(uers_pkg::SOUND_NUM);
		wide = WIDE_W'(prod / uers_pkg::SOUND_DEN);
		if (wide > WIDE_W'(uers_pkg::DIST_MAX)) begin
			distance_um = uers_pkg::DIST_MAX;
		end else begin
			distance_um = wide[uers_pkg::DIST_W-1:0];
		end
	end
endmodule

@@ rtl/uers_ctrl.sv @@
// Arming, edge capture, chaining and travel-time store for the four sensors.
// Depends on uers_pkg and uers_range_calc.
module uers_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  uers_pkg::cmd_t   cmd,
	output uers_pkg::res_t   res
);
	localparam int unsigned UB = uers_pkg::USED_BITS;

	logic                    armed_q, armed_d;
	uers_pkg::sensor_t       armed_sensor_q, armed_sensor_d;
	logic                    rise_seen_q, rise_seen_d;
	logic [UB-1:0]           rise_stamp_q, rise_stamp_d;
	logic [UB-1:0]           travel_q [uers_pkg::SENSOR_COUNT];
	logic                    tt_we;
	logic [UB-1:0]           tt_wdata;
	logic [UB-1:0]           stamp;
	logic [uers_pkg::DIST_W-1:0] range_um;

	assign stamp = cmd.stamp[UB-1:0];

	uers_range_calc u_range (
		.travel      (travel_q[cmd.sensor]),
		.distance_um (range_um)
	);

	// Decode the command, compute the result and the next state
	always_comb begin
		res            = '0;
		armed_d        = armed_q;
		armed_sensor_d = armed_sensor_q;
		rise_seen_d    = rise_seen_q;
		rise_stamp_d   = rise_stamp_q;
		tt_we          = 1'b0;
		tt_wdata       = stamp - rise_stamp_q;
		unique case (cmd.func)
			uers_pkg::FUNC_START: begin
				armed_d        = 1'b1;
				armed_sensor_d = cmd.sensor;
				rise_seen_d    = 1'b0;
				if (cmd.sensor != uers_pkg::POS_BACK) begin
					res.trig_fire   = 1'b1;
					res.trig_sensor = cmd.sensor;
				end
			end
			uers_pkg::FUNC_EDGE: begin
				if (armed_q && armed_sensor_q == cmd.sensor) begin
					if (!rise_seen_q) begin
						rise_stamp_d = stamp;
						rise_seen_d  = 1'b1;
					end else begin
						res.done_res    = 1'b1;
						res.done_sensor = cmd.sensor;
						// Keep only a strictly later fall; a wrap is dropped
						if (stamp > rise_stamp_q) begin
							tt_we           = 1'b1;
							res.sample_kept = 1'b1;
						end
						rise_seen_d = 1'b0;
						armed_d     = 1'b0;
						// Chain left to front, front to right
						if (cmd.sensor == uers_pkg::POS_LEFT) begin
							armed_d         = 1'b1;
							armed_sensor_d  = uers_pkg::POS_FRONT;
							res.trig_fire   = 1'b1;
							res.trig_sensor = uers_pkg::POS_FRONT;
						end else if (cmd.sensor == uers_pkg::POS_FRONT) begin
							armed_d         = 1'b1;
							armed_sensor_d  = uers_pkg::POS_RIGHT;
							res.trig_fire   = 1'b1;
							res.trig_sensor = uers_pkg::POS_RIGHT;
						end
					end
				end
			end
			uers_pkg::FUNC_READ: begin
				res.read_valid  = 1'b1;
				res.distance_um = range_um;
			end
			default: begin
			end
		endcase
	end

	// Commit state when the command moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q        <= 1'b0;
			armed_sensor_q <= uers_pkg::POS_FRONT;
			rise_seen_q    <= 1'b0;
			rise_stamp_q   <= '0;
			for (int i = 0; i < uers_pkg::SENSOR_COUNT; i++) begin
				travel_q[i] <= '0;
			end
		end else if (adv) begin
			armed_q        <= armed_d;
			armed_sensor_q <= armed_sensor_d;
			rise_seen_q    <= rise_seen_d;
			rise_stamp_q   <= rise_stamp_d;
			if (tt_we) begin
				travel_q[cmd.sensor] <= tt_wdata;
			end
		end
	end

	// A captured rise implies a sensor is armed
	a_rise_needs_arm: assert property (@(posedge clk) disable iff (!arst_n)
		rise_seen_q |-> armed_q)
		else $error("rise captured with no sensor armed");

	// A completion always disarms unless the chain rearms the next sensor
	a_done_disarm: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.done_res && !res.trig_fire) |=> !armed_q)
		else $error("sensor still armed after completion");
endmodule

@@ test/tb_ultrasonic_echo_ranging_sequencer.sv @@
// Testbench for the ultrasonic echo ranging sequencer: directed table, then random sequences.
// Every transfer is scored against its typed table answer or else an in-bench ranging predictor.
// Depends on uers_pkg, uers_cmd_if, uers_res_if and the ultrasonic_echo_ranging_sequencer RTL.
`timescale 1ns / 100ps

module tb_ultrasonic_echo_ranging_sequencer;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RANDOM_ITEMS = 700;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned SW = uers_pkg::STAMP_W;
	localparam logic [SW-1:0] STAMP_KEEP = SW'((64'd1 << uers_pkg::USED_BITS) - 1);

	typedef struct {
		uers_pkg::func_t   func;
		uers_pkg::sensor_t sensor;
		logic [SW-1:0]     stamp;
		bit                typed;
		uers_pkg::res_t    want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	uers_cmd_if cmd ();
	uers_res_if res ();

	ultrasonic_echo_ranging_sequencer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd.sink),
		.res    (res.source)
	);

	// Predictor state
	bit                is_armed;
	uers_pkg::sensor_t live_sensor;
	bit                rise_pending;
	logic [SW-1:0]     rise_at;
	logic [SW-1:0]     travel_us [uers_pkg::SENSOR_COUNT];

	uers_pkg::res_t echo_results_q [$];
	// Per command: typed answer from the table, or defer to the predictor
	stim_row_t row_answer_q [$];

	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int unsigned items_sent = 0;
	int unsigned tx_burst_left = 0;
	int unsigned rx_burst_left = 0;

	always #6 clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic uers_pkg::res_t make_res(bit tf, uers_pkg::sensor_t ts, bit dn,
		uers_pkg::sensor_t ds, bit kept, bit rv, logic [uers_pkg::DIST_W-1:0] range_um);
		uers_pkg::res_t r;
		r.trig_fire   = tf;
		r.trig_sensor = ts;
		r.done_res    = dn;
		r.done_sensor = ds;
		r.sample_kept = kept;
		r.read_valid  = rv;
		r.distance_um = range_um;
		return r;
	endfunction

	function automatic stim_row_t make_row(uers_pkg::func_t f, uers_pkg::sensor_t s,
		logic [SW-1:0] st, bit typed, uers_pkg::res_t want);
		stim_row_t row;
		row.func   = f;
		row.sensor = s;
		row.stamp  = st;
		row.typed  = typed;
		row.want   = want;
		return row;
	endfunction

	// Arm a sensor and pulse its trigger; the back sensor has no trigger line
	function automatic void arm_sensor(uers_pkg::sensor_t s, ref uers_pkg::res_t r);
		is_armed     = 1'b1;
		live_sensor  = s;
		rise_pending = 1'b0;
		if (s != uers_pkg::POS_BACK) begin
			r.trig_fire   = 1'b1;
			r.trig_sensor = s;
		end
	endfunction

	// Advance the predictor by one command and return its result
	function automatic uers_pkg::res_t ranging_step(uers_pkg::func_t f, uers_pkg::sensor_t s,
		logic [SW-1:0] st);
		uers_pkg::res_t r;
		logic [SW-1:0] t;
		logic [31:0] prod;
		r = '0;
		t = st & STAMP_KEEP;
		case (f)
			uers_pkg::FUNC_START: begin
				arm_sensor(s, r);
			end
			uers_pkg::FUNC_EDGE: begin
				if (is_armed && live_sensor == s) begin
					if (!rise_pending) begin
						rise_at      = t;
						rise_pending = 1'b1;
					end else begin
						r.done_res    = 1'b1;
						r.done_sensor = s;
						// Keep only a strictly later fall; equal or wrapped stamps drop
						if (t > rise_at) begin
							travel_us[s]  = (t - rise_at) & STAMP_KEEP;
							r.sample_kept = 1'b1;
						end
						rise_pending = 1'b0;
						is_armed     = 1'b0;
						if (s == uers_pkg::POS_LEFT)
							arm_sensor(uers_pkg::POS_FRONT, r);
						else if (s == uers_pkg::POS_FRONT)
							arm_sensor(uers_pkg::POS_RIGHT, r);
					end
				end
			end
			uers_pkg::FUNC_READ: begin
				prod = (32'(travel_us[s]) * uers_pkg::SOUND_NUM) / uers_pkg::SOUND_DEN;
				r.read_valid  = 1'b1;
				r.distance_um = (prod > 32'(uers_pkg::DIST_MAX)) ? uers_pkg::DIST_MAX :
					prod[uers_pkg::DIST_W-1:0];
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Score results first, then log the command accepted at the same edge
	always @(posedge clk) begin
		uers_pkg::res_t act;
		uers_pkg::res_t want;
		uers_pkg::res_t pred;
		stim_row_t row;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				act.trig_fire   = res.trig_fire;
				act.trig_sensor = res.trig_sensor;
				act.done_res    = res.done_res;
				act.done_sensor = res.done_sensor;
				act.sample_kept = res.sample_kept;
				act.read_valid  = res.read_valid;
				act.distance_um = res.distance_um;
				if (echo_results_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transfer: %p", act);
				end else begin
					want = echo_results_q.pop_front();
					if (act.trig_fire !== want.trig_fire || act.trig_sensor !== want.trig_sensor
						|| act.done_res !== want.done_res
						|| act.done_sensor !== want.done_sensor
						|| act.sample_kept !== want.sample_kept
						|| act.read_valid !== want.read_valid
						|| act.distance_um !== want.distance_um) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch at cycle %0d: expected %p, actual %p",
								cycles, want, act);
					end
				end
			end
			if (cmd.valid && cmd.ready) begin
				row = row_answer_q.pop_front();
				pred = ranging_step(uers_pkg::func_t'(cmd.func),
					uers_pkg::sensor_t'(cmd.sensor), cmd.stamp);
				echo_results_q.push_back(row.typed ? row.want : pred);
			end
		end
	end

	// Draw an idle gap, with occasional stretches of none
	function automatic int unsigned draw_gap(ref int unsigned burst_left);
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0)
			burst_left = $urandom_range(10, 40);
		return $urandom_range(0, 18);
	endfunction

	// Result side: hold ready low for a drawn stall before each transfer
	initial begin
		int unsigned w;
		res.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			w = draw_gap(rx_burst_left);
			if (w > 0) begin
				res.ready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			res.ready <= 1'b1;
			@(posedge clk);
			while (!res.valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	// Drive one command transfer; called at a falling edge, returns at one
	task automatic send_cmd(uers_pkg::func_t f, uers_pkg::sensor_t s, logic [SW-1:0] st,
		bit typed = 1'b0, uers_pkg::res_t want = '0);
		int unsigned gap;
		gap = draw_gap(tx_burst_left);
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		row_answer_q.push_back(make_row(f, s, st, typed, want));
		cmd.valid  <= 1'b1;
		cmd.func   <= f;
		cmd.sensor <= s;
		cmd.stamp  <= st;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		@(negedge clk);
		if (f != uers_pkg::FUNC_NONE)
			items_sent++;
	endtask

	function automatic logic [SW-1:0] pick_rise();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return SW'($urandom);
		endcase
	endfunction

	function automatic logic [SW-1:0] pick_fall(logic [SW-1:0] rise);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (rise == '1 || r == 0)
			return rise;
		if (r == 1)
			return SW'($urandom);
		return SW'(int'(rise) + $urandom_range(1, 65535 - int'(rise)));
	endfunction

	function automatic uers_pkg::sensor_t any_sensor();
		return uers_pkg::sensor_t'($urandom_range(0, 3));
	endfunction

	// One well-formed measurement, following the chain, with some noise and breaks
	task automatic run_chain(uers_pkg::sensor_t first);
		uers_pkg::sensor_t cur;
		logic [SW-1:0] rise;
		bit more;
		cur  = first;
		more = 1'b1;
		send_cmd(uers_pkg::FUNC_START, cur, SW'($urandom));
		while (more) begin
			if ($urandom_range(0, 5) == 0)
				send_cmd(uers_pkg::FUNC_EDGE,
					uers_pkg::sensor_t'((cur + $urandom_range(1, 3)) % 4), SW'($urandom));
			rise = pick_rise();
			send_cmd(uers_pkg::FUNC_EDGE, cur, rise);
			if ($urandom_range(0, 9) == 0)
				send_cmd(uers_pkg::FUNC_READ, any_sensor(), SW'($urandom));
			// Restart mid-measurement and drop the half-taken sample
			if ($urandom_range(0, 19) == 0) begin
				send_cmd(uers_pkg::FUNC_START, any_sensor(), SW'($urandom));
				return;
			end
			send_cmd(uers_pkg::FUNC_EDGE, cur, pick_fall(rise));
			if (cur == uers_pkg::POS_LEFT)
				cur = uers_pkg::POS_FRONT;
			else if (cur == uers_pkg::POS_FRONT)
				cur = uers_pkg::POS_RIGHT;
			else
				more = 1'b0;
		end
		send_cmd(uers_pkg::FUNC_READ, any_sensor(), SW'($urandom));
	endtask

	// Stimulus and end of run
	initial begin
		stim_row_t rows [25];
		int unsigned r;
		is_armed     = 1'b0;
		live_sensor  = uers_pkg::POS_FRONT;
		rise_pending = 1'b0;
		rise_at      = '0;
		foreach (travel_us[i])
			travel_us[i] = '0;
		cmd.valid  = 1'b0;
		cmd.func   = uers_pkg::FUNC_NONE;
		cmd.sensor = uers_pkg::POS_FRONT;
		cmd.stamp  = '0;

		rows[0]  = make_row(uers_pkg::FUNC_READ, uers_pkg::POS_FRONT, '0, 1,
			make_res(0, uers_pkg::POS_FRONT, 0, uers_pkg::POS_FRONT, 0, 1, '0));
		rows[1]  = make_row(uers_pkg::FUNC_READ, uers_pkg::POS_RIGHT, '1, 1,
			make_res(0, uers_pkg::POS_FRONT, 0, uers_pkg::POS_FRONT, 0, 1, '0));
		rows[2]  = make_row(uers_pkg::FUNC_NONE, uers_pkg::POS_RIGHT, '1, 1, '0);
		rows[3]  = make_row(uers_pkg::FUNC_EDGE, uers_pkg::POS_FRONT, 16'h1234, 1, '0);
		rows[4]  = make_row(uers_pkg::FUNC_START, uers_pkg::POS_FRONT, '0, 1,
			make_res(1, uers_pkg::POS_FRONT, 0, uers_pkg::POS_FRONT, 0, 0, '0));
		rows[5]  = make_row(uers_pkg::FUNC_EDGE, uers_pkg::POS_BACK, 16'h0010, 1, '0);
		rows[6]  = make_row(uers_pkg::FUNC_EDGE, uers_pkg::POS_FRONT, '0, 1, '0);
		rows[7]  = make_row(uers_pkg::FUNC_EDGE, uers_pkg::POS_FRONT, '1, 1,
			make_res(1, uers_pkg::POS_RIGHT, 1, uers_pkg::POS_FRONT, 1, 0, '0));
		rows[8]  = make_row(uers_pkg::FUNC_READ, uers_pkg::POS_FRONT, '0, 1,
			make_res(0, uers_pkg::POS_FRONT, 0, uers_pkg::POS_FRONT, 0, 1, 24'd11239252));
		rows[9]  = make_row(uers_pkg::FUNC_EDGE, uers_pkg::POS_RIGHT, 16'd100, 0, '0);
		rows[10] = make_row(uers_pkg::FUNC_EDGE, uers_pkg::POS_RIGHT, 16'd100, 1,
			make_res(0, uers_pkg::POS_FRONT, 1, uers_pkg::POS_RIGHT, 0, 0, '0));
		rows[11] = make_row(uers_pkg::FUNC_READ, uers_pkg::POS_RIGHT, '0, 0, '0);
		rows[12] = make_row(uers_pkg::FUNC_START, uers_pkg::POS_BACK, '0, 1, '0);
		rows[13] = make_row(uers_pkg::FUNC_EDGE, uers_pkg::POS_BACK, 16'h8000, 0, '0);
		rows[14] = make_row(uers_pkg::FUNC_EDGE, uers_pkg::POS_BACK, 16'h7FFF, 0, '0);
		rows[15] = make_row(uers_pkg::FUNC_START, uers_pkg::POS_LEFT, '0, 1,
			make_res(1, uers_pkg::POS_LEFT, 0, uers_pkg::POS_FRONT, 0, 0, '0));
		rows[16] = make_row(uers_pkg::FUNC_EDGE, uers_pkg::POS_LEFT, 16'd1000, 0, '0);
		rows[17] = make_row(uers_pkg::FUNC_EDGE, uers_pkg::POS_LEFT, 16'd1001, 0, '0);
		rows[18] = make_row(uers_pkg::FUNC_READ, uers_pkg::POS_LEFT, '0, 0, '0);
		rows[19] = make_row(uers_pkg::FUNC_EDGE, uers_pkg::POS_FRONT, 16'd5, 0, '0);
		rows[20] = make_row(uers_pkg::FUNC_START, uers_pkg::POS_RIGHT, '0, 0, '0);
		rows[21] = make_row(uers_pkg::FUNC_EDGE, uers_pkg::POS_FRONT, 16'd9, 0, '0);
		rows[22] = make_row(uers_pkg::FUNC_EDGE, uers_pkg::POS_RIGHT, 16'h5555, 0, '0);
		rows[23] = make_row(uers_pkg::FUNC_EDGE, uers_pkg::POS_RIGHT, 16'hAAAA, 0, '0);
		rows[24] = make_row(uers_pkg::FUNC_READ, uers_pkg::POS_RIGHT, '0, 0, '0);

		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table
		foreach (rows[i])
			send_cmd(rows[i].func, rows[i].sensor, rows[i].stamp, rows[i].typed, rows[i].want);

		// Random part: mostly full measurements, some loose commands
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 9);
			if (r < 7)
				run_chain(any_sensor());
			else if (r < 9)
				send_cmd(uers_pkg::func_t'($urandom_range(0, 3)), any_sensor(), SW'($urandom));
			else
				send_cmd(uers_pkg::FUNC_READ, any_sensor(), SW'($urandom));
		end
		cmd.valid <= 1'b0;

		// Drain outstanding results, then watch for strays
		while (echo_results_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && echo_results_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
